FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDT_ASSERT(lbl, clk, rst, prop, msg)
`define FDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/fdt_pkg.sv
package fdt_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int MAX_NODES   = 8;
   localparam int NODE_W      = 24;
   localparam int FACE_W      = 16;
   localparam int CNT_W       = 4;
   localparam int LEFT_W      = $clog2(TABLE_DEPTH + 1);
   localparam int PHASE_W     = $clog2(MAX_NODES + 1);

   typedef enum logic [1:0] {
      ST_ADDED = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef logic [MAX_NODES-1:0][NODE_W-1:0] keys_type;

   typedef struct packed {
      logic                valid;
      logic                done;
      status_type          status;
      logic [FACE_W-1:0]   face_id;
      logic [CNT_W-1:0]    cnt;
      keys_type            keys;
      logic [FACE_W-1:0]   mid;
      logic [LEFT_W-1:0]   left;
   } query_type;
endpackage

FILE: hdl/fdt_req_if.sv
interface fdt_req_if;
   import fdt_pkg::*;
   logic              valid;
   logic              ready;
   logic [FACE_W-1:0] face_id;
   logic [CNT_W-1:0]  node_count;
   logic [NODE_W-1:0] node_a, node_b, node_c, node_d, node_e, node_f, node_g, node_h;
   modport source (output valid, face_id, node_count, node_a, node_b, node_c, node_d,
                   node_e, node_f, node_g, node_h, input ready);
   modport sink (input valid, face_id, node_count, node_a, node_b, node_c, node_d,
                 node_e, node_f, node_g, node_h, output ready);
endinterface

FILE: hdl/fdt_rsp_if.sv
interface fdt_rsp_if;
   import fdt_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [FACE_W-1:0] matched_face_id;
   modport source (output valid, status, matched_face_id, input ready);
   modport sink (input valid, status, matched_face_id, output ready);
endinterface

FILE: hdl/mesh_face_dedup_table_unit.sv
// channel  | dir | handshake             | payload
// req_ch   | in  | valid/ready           | face_id, node_count, node_a..node_h
// rsp_ch   | out | valid/ready           | status, matched_face_id
// One item at a time: an accept state, MAX_NODES sort phases, an inject step,
// then the item walks the TABLE_DEPTH entry cells, one cell per cycle, and
// lands in the output register. Synchronous reset empties the table.
// A stalled result is held in the output register; a new item may be
// accepted meanwhile and waits at the chain end for the register to free.
`include "assert_macros.svh"
module mesh_face_dedup_table_unit (
   input logic       clock,
   input logic       reset,
   fdt_req_if.sink   req_ch,
   fdt_rsp_if.source rsp_ch
);
   import fdt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SORT, S_CHAIN, S_OUT} state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [FACE_W-1:0] id_ff;
   logic [LEFT_W-1:0] fill_ff;
   query_type         head_ff, tail_q;
   query_type         chain [TABLE_DEPTH+1];
   logic              rsp_valid_ff;
   status_type        rsp_status_ff, res_status_ff;
   logic [FACE_W-1:0] rsp_mid_ff, res_mid_ff;
   logic              sort_start, sort_done;
   keys_type          in_nodes, sorted;
   logic [CNT_W-1:0]  sat_cnt;

   assign req_ch.ready = state_ff == S_IDLE;
   assign sat_cnt = (req_ch.node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : req_ch.node_count;
   assign sort_start = req_ch.valid && req_ch.ready;
   assign in_nodes = {req_ch.node_h, req_ch.node_g, req_ch.node_f, req_ch.node_e,
                      req_ch.node_d, req_ch.node_c, req_ch.node_b, req_ch.node_a};

   fdt_sorter u_sort (
      .clock(clock), .reset(reset), .start(sort_start), .cnt(sat_cnt),
      .nodes(in_nodes), .done(sort_done), .keys(sorted)
   );

   assign chain[0] = head_ff;
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      fdt_cell u_cell (.clock(clock), .reset(reset), .q_in(chain[g]), .q_out(chain[g+1]));
   end
   assign tail_q = chain[TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (sort_start) begin
               cnt_ff   <= sat_cnt;
               id_ff    <= req_ch.face_id;
               state_ff <= S_SORT;
            end
            S_SORT: if (sort_done) begin
               head_ff  <= '{valid: 1'b1, done: 1'b0, status: ST_ADDED, face_id: id_ff,
                             cnt: cnt_ff, keys: sorted, mid: '0, left: fill_ff};
               state_ff <= S_CHAIN;
            end
            S_CHAIN: begin
               // injected item stays valid for one cycle only
               head_ff.valid <= 1'b0;
               if (tail_q.valid) begin
                  res_status_ff <= tail_q.done ? tail_q.status : ST_FULL;
                  res_mid_ff    <= (tail_q.done && tail_q.status == ST_DUP) ? tail_q.mid : '0;
                  if (tail_q.done && tail_q.status == ST_ADDED)
                     fill_ff <= fill_ff + LEFT_W'(1);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= res_status_ff;
               rsp_mid_ff    <= res_mid_ff;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.matched_face_id = rsp_mid_ff;

   `FDT_ASSERT(a_fill_bound, clock, reset, fill_ff <= LEFT_W'(TABLE_DEPTH), "fill overrun")
   `FDT_ASSERT(a_full_only_at_depth, clock, reset, (tail_q.valid && !tail_q.done) |-> (fill_ff == LEFT_W'(TABLE_DEPTH)), "face dropped before table full")
   `FDT_ASSERT(a_sort_in_state, clock, reset, sort_done |-> (state_ff == S_SORT), "sort done out of sequence")
   `FDT_ASSERT(a_tail_in_state, clock, reset, tail_q.valid |-> (state_ff == S_CHAIN), "chain item out of sequence")
endmodule

FILE: hdl/fdt_sorter.sv
module fdt_sorter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [fdt_pkg::CNT_W-1:0] cnt,
   input  fdt_pkg::keys_type        nodes,
   output logic                     done,
   output fdt_pkg::keys_type        keys
);
   import fdt_pkg::*;

   // MSB flags an unused slot so it sorts after every real id
   logic [MAX_NODES-1:0][NODE_W:0] work_ff, work_in;
   logic [PHASE_W-1:0]             phase_ff;
   logic                           run_ff, done_ff;

   always_comb begin
      work_in = work_ff;
      for (int i = 0; i < MAX_NODES - 1; i++) begin
         if ((i % 2) == int'(phase_ff[0]) && work_ff[i+1] < work_ff[i]) begin
            work_in[i]   = work_ff[i+1];
            work_in[i+1] = work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            phase_ff <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
               if (CNT_W'(i) < cnt) work_ff[i] <= {1'b0, nodes[i]};
               else                 work_ff[i] <= {1'b1, {NODE_W{1'b0}}};
            end
         end else if (run_ff) begin
            work_ff  <= work_in;
            phase_ff <= phase_ff + PHASE_W'(1);
            if (phase_ff == PHASE_W'(MAX_NODES - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++)
         keys[i] = work_ff[i][NODE_W] ? '0 : work_ff[i][NODE_W-1:0];
   end
   assign done = done_ff;
endmodule

FILE: hdl/fdt_cell.sv
module fdt_cell (
   input  logic               clock,
   input  logic               reset,
   input  fdt_pkg::query_type q_in,
   output fdt_pkg::query_type q_out
);
   import fdt_pkg::*;

   query_type         q_ff, q_in_next;
   logic [CNT_W-1:0]  cnt_ff;
   keys_type          keys_ff;
   logic [FACE_W-1:0] id_ff;
   logic              occupied, hit, app;

   assign occupied = q_in.left != '0;
   assign hit = q_in.valid && !q_in.done && occupied && q_in.cnt == cnt_ff
                && q_in.keys == keys_ff;
   // first free cell takes the face when nothing upstream matched
   assign app = q_in.valid && !q_in.done && !occupied;

   always_comb begin
      q_in_next      = q_in;
      q_in_next.left = occupied ? q_in.left - LEFT_W'(1) : '0;
      if (hit) begin
         q_in_next.done   = 1'b1;
         q_in_next.status = ST_DUP;
         q_in_next.mid    = id_ff;
      end else if (app) begin
         q_in_next.done   = 1'b1;
         q_in_next.status = ST_ADDED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_ff <= '0;
      else       q_ff <= q_in_next;
      if (app) begin
         cnt_ff  <= q_in.cnt;
         keys_ff <= q_in.keys;
         id_ff   <= q_in.face_id;
      end
   end

   assign q_out = q_ff;
endmodule
